@@ rtl/fba_pkg.sv @@
package fba_pkg;

  // Default table geometry.
  localparam int FBA_MAX_BLOCKS = 32;
  localparam int FBA_SIZE_BITS  = 16;

  // Fixed widths of the transaction fields and registers.
  localparam int INDEX_W = 5;
  localparam int AMOUNT_W = 16;
  localparam int MODE_W = 2;
  localparam int COUNT_W = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Placement policies. The unused code behaves as first fit.
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Input transaction kinds.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // Register indexes, taken from the word address.
  typedef enum logic {
    REG_FIT_MODE      = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHARGE,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/fit_block_allocator.sv @@
// Free-space allocator over a table of memory blocks.
//
// Input channel (in_valid/in_ready, fields action, block_index, amount):
// a load transaction writes one block's capacity and produces no result;
// a request transaction asks for an amount and produces exactly one
// result on the output channel (out_valid/out_ready, fields granted,
// chosen_block, space_left).
// A load is written when accepted, and the next transaction can follow at once.
// A request scans the entries in use one per cycle through the table
// memory's single read port and a shared compare unit, then charges the
// chosen entry; in_ready stays low from acceptance until the result is
// loaded into the output register, where it sits. If the receiver stalls,
// loads are still taken, and a later request waits in its result state
// until the register frees up. Reset clears the whole table to zero at
// once (per-entry valid bits), sets first fit and 32 blocks in use; no
// clearing pass is needed. Configuration is written over the APB port;
// the user must write it only while the block is idle, which the block
// itself does not enforce.
module fit_block_allocator #(
  parameter int MAX_BLOCKS = fba_pkg::FBA_MAX_BLOCKS,
  parameter int SIZE_BITS  = fba_pkg::FBA_SIZE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fba_pkg::PADDR_W-1:0]   paddr,
  input  logic [fba_pkg::PDATA_W-1:0]   pwdata,
  output logic [fba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [fba_pkg::INDEX_W-1:0]   block_index,
  input  logic [fba_pkg::AMOUNT_W-1:0]  amount,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          granted,
  output logic [fba_pkg::INDEX_W-1:0]   chosen_block,
  output logic [fba_pkg::AMOUNT_W-1:0]  space_left
);

  import fba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // Configuration registers.
  logic [MODE_W-1:0]  fit_mode;
  logic [COUNT_W-1:0] blocks_in_use;

  // Sequencer and scan state.
  state_t               state, state_next;
  logic [CNT_W-1:0]     rd_cnt;
  logic                 cmp_valid;
  logic [IDX_W-1:0]     cmp_idx;
  logic [SIZE_BITS-1:0] amt;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;
  logic [MAX_BLOCKS-1:0] valid_bits;

  // Combinational control.
  logic                 in_fire;
  logic                 load_fire;
  logic                 req_fire;
  logic                 load_in_range;
  logic [CNT_W-1:0]     limit;
  logic                 issue;
  logic                 scan_done;
  logic                 out_free;
  logic                 cfg_write;
  logic [SIZE_BITS-1:0] entry;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] remainder;

  // Table memory ports.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  fba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Configuration port. Register index comes from address bit 2.
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= FIT_FIRST;
      blocks_in_use <= COUNT_W'(32);
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[2]))
        REG_FIT_MODE:      fit_mode      <= pwdata[MODE_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= pwdata[COUNT_W-1:0];
        default:           fit_mode      <= fit_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_FIT_MODE:      prdata = PDATA_W'(fit_mode);
      REG_BLOCKS_IN_USE: prdata = PDATA_W'(blocks_in_use);
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshake and scan control.
  // ------------------------------------------------------------------
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (action == ACT_LOAD);
  assign req_fire  = in_fire && (action == ACT_REQUEST);
  assign out_free  = !out_valid || out_ready;

  // Loads beyond the table are dropped.
  assign load_in_range = 32'(block_index) < MAX_BLOCKS;

  // A count above the table size scans the whole table.
  assign limit = (32'(blocks_in_use) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                   : CNT_W'(blocks_in_use);

  assign issue     = (state == ST_SCAN) && (rd_cnt < limit);
  assign scan_done = (state == ST_SCAN) && !issue && !cmp_valid;

  // Shared compare unit: the entry read last cycle against the request
  // and against the best candidate so far. Entries never written since
  // reset read as zero.
  assign entry = valid_bits[cmp_idx] ? ram_rdata : '0;
  assign fits  = entry >= amt;

  always_comb begin
    take = 1'b0;
    if (cmp_valid && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_mode == FIT_BEST) begin
        take = entry < best;
      end else if (fit_mode == FIT_WORST) begin
        take = entry > best;
      end
    end
  end

  assign remainder = best - amt;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req_fire) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_CHARGE;
      ST_CHARGE: state_next = ST_RESULT;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and the table write port.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(32'(block_index));
    ram_wdata = SIZE_BITS'(32'(amount));
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = load_fire && load_in_range;
      end
      ST_CHARGE: begin
        ram_we    = found;
        ram_waddr = pick;
        ram_wdata = remainder;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cmp_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_cnt <= '0;
      found  <= 1'b0;
      pick   <= '0;
      best   <= '0;
      amt    <= SIZE_BITS'(32'(amount));
    end else if (state == ST_SCAN) begin
      if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (take) begin
        found <= 1'b1;
        pick  <= cmp_idx;
        best  <= entry;
      end
    end else if (state == ST_CHARGE) begin
      // After charging, best holds the space left in the chosen entry.
      best <= found ? remainder : '0;
      pick <= found ? pick : '0;
    end
    cmp_idx <= rd_cnt[IDX_W-1:0];
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      granted      <= found;
      chosen_block <= INDEX_W'(32'(pick));
      space_left   <= AMOUNT_W'(32'(best));
    end
  end

endmodule

@@ rtl/fba_ram.sv @@
module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/tb.sv @@
module tb;
  import fba_pkg::*;

  // Table geometry of the instance under test.
  localparam int NUM_BLOCKS = FBA_MAX_BLOCKS;

  // The fourth fit-mode code has no name in the package; the block treats it as first fit.
  localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;

  // A request scans at most 32 entries and then charges one, so the block is idle again well
  // before this wait ends once its last result has left.
  localparam int SETTLE_CYCLES = 80;

  // The run is declared dead when no transaction comes before this limit runs out. The longest
  // correct quiet stretch is the deliberate receiver hold-off plus one request.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  localparam int SEGMENTS = 12;
  localparam int ITEMS_PER_SEGMENT = 120;

  // One allocation outcome, laid out as the output transaction carries it.
  typedef struct packed {
    logic                granted;
    logic [INDEX_W-1:0]  block;
    logic [AMOUNT_W-1:0] space;
  } alloc_result_t;

  // A directed row is either an input transaction or a register write.
  typedef enum logic {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                act;
    logic [INDEX_W-1:0]  idx;
    // Capacity for a load, size for a request, or the value of a register write.
    logic [AMOUNT_W-1:0] amt;
    reg_index_t          target;
    // When set, res holds the outcome typed into the table instead of the predicted one.
    logic                known;
    alloc_result_t       res;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_LOAD;
  logic [INDEX_W-1:0]  block_index = '0;
  logic [AMOUNT_W-1:0] amount = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                granted;
  logic [INDEX_W-1:0]  chosen_block;
  logic [AMOUNT_W-1:0] space_left;

  // Sideband that travels with the input payload: it tells the checker that the
  // transaction on the port has an outcome typed into the directed table.
  logic                known_now = 1'b0;
  alloc_result_t       known_res = '0;

  // Our own copy of the block: the free-space table and both registers.
  logic [AMOUNT_W-1:0] space_tbl [NUM_BLOCKS];
  logic [MODE_W-1:0]   mode_cfg = FIT_FIRST;
  logic [COUNT_W-1:0]  blocks_cfg = 6'd32;

  // Outcomes of accepted requests, oldest first, waiting for their output transaction.
  alloc_result_t       pending_grants [$];

  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_left = 0;

  stim_row_t           dir_rows [24];
  logic [MODE_W-1:0]   mode_plan [SEGMENTS];
  int                  count_plan [SEGMENTS];

  fit_block_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .block_index  (block_index),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .chosen_block (chosen_block),
    .space_left   (space_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      space_tbl[i] = '0;
    end
  end

  // Runs one request against the table copy: scan the entries in use, pick one by the
  // current policy, charge it and return what the block should report.
  function automatic alloc_result_t charge_request(input logic [AMOUNT_W-1:0] need);
    alloc_result_t r;
    int            scan_n;
    bit            hit;
    int            pick;
    r = '0;
    hit = 1'b0;
    pick = 0;
    // A count above the table size just scans the whole table.
    scan_n = (int'(blocks_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_cfg);
    for (int j = 0; j < scan_n; j++) begin
      if (space_tbl[j] >= need) begin
        if (!hit) begin
          hit = 1'b1;
          pick = j;
          // First fit, and the unused code that behaves like it, stop at the first match.
          if (mode_cfg != FIT_BEST && mode_cfg != FIT_WORST) break;
        end else if (mode_cfg == FIT_BEST && space_tbl[j] < space_tbl[pick]) begin
          pick = j;
        end else if (mode_cfg == FIT_WORST && space_tbl[j] > space_tbl[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) begin
      space_tbl[pick] = space_tbl[pick] - need;
      r.granted = 1'b1;
      r.block = INDEX_W'(pick);
      r.space = space_tbl[pick];
    end
    return r;
  endfunction

  function automatic stim_row_t load_row(input logic [INDEX_W-1:0] idx,
                                         input logic [AMOUNT_W-1:0] amt);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.act = ACT_LOAD;
    r.idx = idx;
    r.amt = amt;
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic [AMOUNT_W-1:0] amt);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.act = ACT_REQUEST;
    r.amt = amt;
    return r;
  endfunction

  function automatic stim_row_t req_known(input logic [AMOUNT_W-1:0] amt, input logic g,
                                          input logic [INDEX_W-1:0] b,
                                          input logic [AMOUNT_W-1:0] s);
    stim_row_t r;
    r = req_row(amt);
    r.known = 1'b1;
    r.res = '{granted: g, block: b, space: s};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input reg_index_t target,
                                        input logic [AMOUNT_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.target = target;
    r.amt = value;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Offers one input transaction and returns at the clock edge that accepts it. The
  // random idle cycles in front of it are how the sender leaves gaps.
  task automatic drive_item(input logic act, input logic [INDEX_W-1:0] idx,
                            input logic [AMOUNT_W-1:0] amt, input logic known,
                            input alloc_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    block_index <= idx;
    amount <= amt;
    known_now <= known;
    known_res <= res;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Drops valid, waits for every outstanding result and then lets a trailing load finish.
  // After this the block is idle.
  task automatic wait_idle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, access cycle, then a spare cycle so that a following
  // write never drives psel twice in the same step.
  task automatic write_reg(input reg_index_t target, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({target, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (target == REG_FIT_MODE) begin
      mode_cfg = value[MODE_W-1:0];
    end else begin
      blocks_cfg = value[COUNT_W-1:0];
    end
    @(posedge clk);
  endtask

  // Random transaction. Loads mostly fill the entries that are scanned, with capacities
  // a little above the typical request, so that grants and refusals both stay common.
  // Some requests ask for exactly what an entry holds, which sets up exact fits and ties.
  task automatic rand_item;
    logic                act;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;
    int                  roll;
    act = ($urandom_range(99) < 40) ? ACT_LOAD : ACT_REQUEST;
    idx = INDEX_W'($urandom_range(NUM_BLOCKS - 1));
    if (act == ACT_LOAD && blocks_cfg > 0 && int'(blocks_cfg) < NUM_BLOCKS
        && $urandom_range(99) < 70) begin
      idx = INDEX_W'($urandom_range(int'(blocks_cfg) - 1));
    end
    roll = $urandom_range(99);
    if (act == ACT_LOAD) begin
      if (roll < 10) amt = '0;
      else if (roll < 20) amt = '1;
      else if (roll < 35) amt = AMOUNT_W'($urandom);
      else amt = AMOUNT_W'($urandom_range(1000, 50));
    end else begin
      if (roll < 5) amt = '0;
      else if (roll < 10) amt = '1;
      else if (roll < 20) amt = AMOUNT_W'($urandom);
      else if (roll < 35) amt = space_tbl[$urandom_range(NUM_BLOCKS - 1)];
      else amt = AMOUNT_W'($urandom_range(400, 1));
    end
    drive_item(act, idx, amt, 1'b0, '0);
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off while hold_left runs
  // down. During the hold-off the sender keeps going, so the output register fills and
  // the block has to stop taking input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Checker. Both channels are sampled at the rising edge, before any of that edge's
  // updates land, so a transaction is seen exactly as it was accepted. A result that
  // leaves at this edge can never be the one for a request accepted at the same edge.
  always @(posedge clk) begin : track
    alloc_result_t got;
    alloc_result_t want;
    alloc_result_t calc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.granted = granted;
        got.block = chosen_block;
        got.space = space_left;
        if (pending_grants.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: granted=%0d block=%0d space=%0d",
                                  got.granted, got.block, got.space));
        end else begin
          want = pending_grants.pop_front();
          if (got.granted !== want.granted || got.block !== want.block
              || got.space !== want.space) begin
            flag_mismatch($sformatf(
                "mismatch: granted=%0d block=%0d space=%0d, expected %0d %0d %0d",
                got.granted, got.block, got.space, want.granted, want.block, want.space));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) begin
          // Every 5-bit index names an entry of the table, so no load is dropped here.
          space_tbl[block_index] = amount;
        end else begin
          // The table copy is charged even when the directed table supplies the outcome.
          calc = charge_request(amount);
          pending_grants.push_back(known_now ? known_res : calc);
        end
      end
    end
  end

  // Watchdog: any transaction on either channel or the register port counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Directed rows. The table starts all zero with first fit over 32 entries: a zero-size
    // request fits entry 0 even though it is empty, and any nonzero one is refused.
    dir_rows = '{
      req_known(16'd0, 1'b1, 5'd0, 16'd0),
      req_known(16'd1, 1'b0, 5'd0, 16'd0),
      load_row(5'd31, 16'hFFFF),
      load_row(5'd0, 16'd100),
      load_row(5'd5, 16'd300),
      load_row(5'd7, 16'd200),
      // Only the full entry can hold the largest size, and it is drained to zero.
      req_known(16'hFFFF, 1'b1, 5'd31, 16'd0),
      req_row(16'd150),
      cfg_row(REG_FIT_MODE, AMOUNT_W'(FIT_BEST)),
      req_row(16'd120),
      // Zero size under best fit lands on the lowest empty entry.
      req_row(16'd0),
      cfg_row(REG_FIT_MODE, AMOUNT_W'(FIT_WORST)),
      req_row(16'd10),
      // Entries 3 and 7 now tie for the most space; the lower index has to win.
      load_row(5'd3, 16'd190),
      req_row(16'd5),
      cfg_row(REG_FIT_MODE, AMOUNT_W'(FIT_UNUSED)),
      req_row(16'd50),
      // With no entries in use every request is refused.
      cfg_row(REG_BLOCKS_IN_USE, 16'd0),
      req_known(16'd0, 1'b0, 5'd0, 16'd0),
      cfg_row(REG_BLOCKS_IN_USE, 16'd63),
      req_row(16'd100),
      cfg_row(REG_BLOCKS_IN_USE, 16'd1),
      load_row(5'd0, 16'hFFFF),
      req_known(16'hFFFF, 1'b1, 5'd0, 16'd0)
    };

    // Settings per random segment. Each policy gets a run over the full table; the extreme
    // counts none and one get one segment each, and more than the table holds gets two.
    mode_plan = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED,
                  FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_FIRST,
                  FIT_WORST, FIT_UNUSED, FIT_FIRST, FIT_BEST};
    count_plan = '{32, 1, 63, 0, 32, 17, 33, 2, 32, 31, 32, 8};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 74;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_rows[i].target, PDATA_W'(dir_rows[i].amt));
      end else begin
        drive_item(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].amt,
                   dir_rows[i].known, dir_rows[i].res);
      end
    end

    // Random part in three stall regimes of four segments each. Every segment starts from
    // an idle block with a fresh pair of register values.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) begin
        send_idle_pct = 13;
        recv_idle_pct = 74;
      end else if (seg == 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 13;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      write_reg(REG_FIT_MODE, PDATA_W'(mode_plan[seg]));
      write_reg(REG_BLOCKS_IN_USE, PDATA_W'(count_plan[seg]));
      // With neither side idling, one long receiver hold-off backs the block up.
      if (seg == 9) begin
        hold_left = HOLD_CYCLES;
      end
      repeat (ITEMS_PER_SEGMENT) rand_item();
    end

    wait_idle();
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
